[rtl/priority_ready_queue_scheduler_core_defines.svh]
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by the checker file only.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH

// Check a property outside reset.
`define PRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/prq_pkg.sv]
// Package for the priority ready queue scheduler: field widths, codes and types.
// Depends on nothing; used by the interfaces, the cell, the top level and the checker.
package prq_pkg;

    localparam int TASKS_DEF = 8;
    localparam int OP_W      = 2;
    localparam int PRIO_W    = 8;
    localparam int ID_W      = 3;
    localparam int OUTC_W    = 2;
    localparam int STAT_W    = 3;
    localparam int CNT_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_RESUME = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_NO_SLOT   = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_QUEUED    = 3'd5
    } t_status;

    localparam logic [OUTC_W-1:0] OUTC_READY = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_TERM  = 2'd2;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_TERM    = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [PRIO_W-1:0]  key_prio;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REQ,
        S_DONE
    } t_state;

endpackage

[rtl/prq_if.sv]
// Valid/ready channel interfaces for the scheduler's request and result beats.
// Depends on prq_pkg for the field widths.
interface prq_in_if import prq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [PRIO_W-1:0] task_priority_in;
    logic [ID_W-1:0]   task_id_in;
    logic [OUTC_W-1:0] current_outcome;

    modport source (output valid, opcode, task_priority_in, task_id_in, current_outcome,
                    input ready);
    modport sink   (input valid, opcode, task_priority_in, task_id_in, current_outcome,
                    output ready);
endinterface

interface prq_out_if import prq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   task_id_out;
    logic [ID_W-1:0]   running_task;
    logic              running_valid;
    logic [CNT_W-1:0]  queue_count;

    modport source (output valid, status, task_id_out, running_task, running_valid,
                    queue_count, input ready);
    modport sink   (input valid, status, task_id_out, running_task, running_valid,
                    queue_count, output ready);
endinterface

[rtl/prq_cell.sv]
// One cell of the sorted ready queue: holds one entry, shifts with its neighbors.
// Depends on prq_pkg for the command struct.
module prq_cell import prq_pkg::*; #(
    parameter int SLOT_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic [SLOT_W-1:0] i_key_id,
    input  logic              i_left_valid,
    input  logic [SLOT_W-1:0] i_left_id,
    input  logic [PRIO_W-1:0] i_left_prio,
    input  logic              i_left_after,
    input  logic              i_left_hit,
    input  logic              i_right_valid,
    input  logic [SLOT_W-1:0] i_right_id,
    input  logic [PRIO_W-1:0] i_right_prio,
    output logic              o_valid,
    output logic [SLOT_W-1:0] o_id,
    output logic [PRIO_W-1:0] o_prio,
    output logic              o_after,
    output logic              o_hit
);

    logic              r_valid, n_valid;
    logic [SLOT_W-1:0] r_id, n_id;
    logic [PRIO_W-1:0] r_prio, n_prio;

    // The new key lands before this cell when the cell is empty or strictly worse.
    assign o_after = !r_valid || (r_prio > i_cmd.key_prio);
    // Once the removed key is seen, every cell from there on pulls from the right.
    assign o_hit   = i_left_hit || (r_valid && (r_id == i_key_id));

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_left_after) begin
                    n_valid = i_left_valid;
                    n_id    = i_left_id;
                    n_prio  = i_left_prio;
                end else if (o_after) begin
                    n_valid = 1'b1;
                    n_id    = i_key_id;
                    n_prio  = i_cmd.key_prio;
                end
            end
            CELL_REMOVE: begin
                if (o_hit) begin
                    n_valid = i_right_valid;
                    n_id    = i_right_id;
                    n_prio  = i_right_prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_prio  = r_prio;

endmodule

[rtl/priority_ready_queue_scheduler_core.sv]
// Top level of the fixed-priority ready queue scheduler with round-robin among equals.
// Depends on prq_pkg, prq_if (channel interfaces) and prq_cell (queue cells).
//
// The scheduler keeps TASKS task slots and a ready queue ordered by priority
// (1 is best, 0 is rejected; equal priorities stay first in, first out). Each
// request beat carries one operation (create, resume, remove, schedule tick)
// and yields exactly one result beat with a status, a task id, the running
// task and the queue length. Requests are handled one at a time: a request
// beat is taken in one cycle and executed in the next, and a tick that swaps
// the running task out requeues it in a further step. The queue is a row of
// TASKS cells that performs one insert or one remove per cycle. A finished
// result sits in an output register, so the next request beat is taken while
// it waits; if that result is still waiting when the following one is done,
// the sequencer holds the following one and takes no request beat until the
// output register frees. No clearing pass is needed after reset.
module priority_ready_queue_scheduler_core import prq_pkg::*; #(
    parameter int TASKS = TASKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    prq_in_if.sink    i_in,
    prq_out_if.source o_out
);

    localparam int SLOT_W = $clog2(TASKS);
    localparam int LEN_W  = $clog2(TASKS + 1);

    // Control state.
    t_state             r_state, n_state;
    t_slot_st           r_slot_st [TASKS];
    t_slot_st           n_slot_st [TASKS];
    logic [TASKS-1:0]   r_in_q, n_in_q;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [SLOT_W-1:0]  r_run_slot, n_run_slot;
    logic               r_run_present, n_run_present;
    logic               r_out_valid;

    // Payload.
    logic [PRIO_W-1:0]  r_slot_prio [TASKS];
    logic [PRIO_W-1:0]  r_run_prio, n_run_prio;
    logic [SLOT_W-1:0]  r_req_slot, n_req_slot;
    logic [PRIO_W-1:0]  r_req_prio, n_req_prio;
    t_op                r_op;
    logic [PRIO_W-1:0]  r_prio_in;
    logic [ID_W-1:0]    r_id_in;
    logic [OUTC_W-1:0]  r_outc;
    t_status            r_res_status, res_status;
    logic [ID_W-1:0]    r_res_id, res_id;
    t_status            r_out_status;
    logic [ID_W-1:0]    r_out_id;
    logic [ID_W-1:0]    r_out_run;
    logic               r_out_run_valid;
    logic [CNT_W-1:0]   r_out_count;

    // Queue cell row.
    t_cell_cmd          cell_cmd;
    logic [SLOT_W-1:0]  key_id;
    logic               c_valid [TASKS];
    logic [SLOT_W-1:0]  c_id    [TASKS];
    logic [PRIO_W-1:0]  c_prio  [TASKS];
    logic               c_after [TASKS];
    logic               c_hit   [TASKS];

    logic               take_in;
    logic               out_free;
    logic               finish;
    logic               load_out;
    logic               prio_we;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic               id_ok;
    logic [SLOT_W-1:0]  slot;

    assign i_in.ready = (r_state == S_IDLE);
    assign take_in    = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    assign id_ok = (int'(r_id_in) < TASKS);
    assign slot  = SLOT_W'(r_id_in);

    // Lowest slot that is unused or terminated and neither queued nor running.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < TASKS; i++) begin
            if (!free_found && (r_slot_st[i] == ST_UNUSED || r_slot_st[i] == ST_TERM)
                    && !r_in_q[i] && !(r_run_present && (r_run_slot == SLOT_W'(i)))) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Row of queue cells; cell 0 is the head.
    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        logic              left_valid, left_after, left_hit, right_valid;
        logic [SLOT_W-1:0] left_id, right_id;
        logic [PRIO_W-1:0] left_prio, right_prio;

        if (g == 0) begin : g_first
            assign left_valid = 1'b0;
            assign left_id    = '0;
            assign left_prio  = '0;
            assign left_after = 1'b0;
            assign left_hit   = 1'b0;
        end else begin : g_rest
            assign left_valid = c_valid[g-1];
            assign left_id    = c_id[g-1];
            assign left_prio  = c_prio[g-1];
            assign left_after = c_after[g-1];
            assign left_hit   = c_hit[g-1];
        end

        if (g == TASKS - 1) begin : g_last
            assign right_valid = 1'b0;
            assign right_id    = '0;
            assign right_prio  = '0;
        end else begin : g_inner
            assign right_valid = c_valid[g+1];
            assign right_id    = c_id[g+1];
            assign right_prio  = c_prio[g+1];
        end

        prq_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cell_cmd),
            .i_key_id      (key_id),
            .i_left_valid  (left_valid),
            .i_left_id     (left_id),
            .i_left_prio   (left_prio),
            .i_left_after  (left_after),
            .i_left_hit    (left_hit),
            .i_right_valid (right_valid),
            .i_right_id    (right_id),
            .i_right_prio  (right_prio),
            .o_valid       (c_valid[g]),
            .o_id          (c_id[g]),
            .o_prio        (c_prio[g]),
            .o_after       (c_after[g]),
            .o_hit         (c_hit[g])
        );
    end

    // Sequencer: capture the beat, run the operation, requeue if needed, deliver.
    always_comb begin
        n_state       = r_state;
        n_slot_st     = r_slot_st;
        n_in_q        = r_in_q;
        n_len         = r_len;
        n_run_slot    = r_run_slot;
        n_run_present = r_run_present;
        n_run_prio    = r_run_prio;
        n_req_slot    = r_req_slot;
        n_req_prio    = r_req_prio;
        cell_cmd      = '{op: CELL_HOLD, key_prio: '0};
        key_id        = '0;
        prio_we       = 1'b0;
        res_status    = r_res_status;
        res_id        = r_res_id;
        finish        = 1'b0;
        load_out      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                res_status = STAT_OK;
                res_id     = r_id_in;
                finish     = 1'b1;
                case (r_op)
                    OP_CREATE: begin
                        if (r_prio_in == '0) begin
                            res_status = STAT_INVALID;
                        end else if (!free_found) begin
                            res_status = STAT_NO_SLOT;
                        end else begin
                            prio_we              = 1'b1;
                            n_slot_st[free_slot] = ST_READY;
                            n_in_q[free_slot]    = 1'b1;
                            n_len                = r_len + LEN_W'(1);
                            cell_cmd             = '{op: CELL_INSERT, key_prio: r_prio_in};
                            key_id               = free_slot;
                            res_id               = ID_W'(free_slot);
                        end
                    end
                    OP_RESUME: begin
                        if (!id_ok) begin
                            res_status = STAT_INVALID;
                        end else if (r_slot_st[slot] == ST_UNUSED) begin
                            res_status = STAT_INVALID;
                        end else if (r_in_q[slot]) begin
                            res_status = STAT_QUEUED;
                        end else begin
                            n_slot_st[slot] = ST_READY;
                            n_in_q[slot]    = 1'b1;
                            n_len           = r_len + LEN_W'(1);
                            cell_cmd        = '{op: CELL_INSERT, key_prio: r_slot_prio[slot]};
                            key_id          = slot;
                        end
                    end
                    OP_REMOVE: begin
                        if (!id_ok) begin
                            res_status = STAT_INVALID;
                        end else if (r_len == '0) begin
                            res_status = STAT_EMPTY;
                        end else if (!r_in_q[slot]) begin
                            res_status = STAT_NOT_FOUND;
                        end else begin
                            n_in_q[slot] = 1'b0;
                            n_len        = r_len - LEN_W'(1);
                            cell_cmd     = '{op: CELL_REMOVE, key_prio: '0};
                            key_id       = slot;
                        end
                    end
                    default: begin
                        // Schedule tick.
                        if (!r_run_present) begin
                            if (r_len == '0) begin
                                res_status = STAT_EMPTY;
                            end else begin
                                n_in_q[c_id[0]] = 1'b0;
                                n_len           = r_len - LEN_W'(1);
                                cell_cmd        = '{op: CELL_REMOVE, key_prio: '0};
                                key_id          = c_id[0];
                                n_run_slot      = c_id[0];
                                n_run_prio      = c_prio[0];
                                n_run_present   = 1'b1;
                            end
                        end else if (r_outc != OUTC_READY) begin
                            n_slot_st[r_run_slot] = (r_outc == OUTC_TERM) ? ST_TERM : ST_BLOCKED;
                            if (r_len == '0) begin
                                n_run_present = 1'b0;
                                n_run_slot    = '0;
                                res_status    = STAT_EMPTY;
                            end else begin
                                n_in_q[c_id[0]] = 1'b0;
                                n_len           = r_len - LEN_W'(1);
                                cell_cmd        = '{op: CELL_REMOVE, key_prio: '0};
                                key_id          = c_id[0];
                                n_run_slot      = c_id[0];
                                n_run_prio      = c_prio[0];
                            end
                        end else begin
                            n_slot_st[r_run_slot] = ST_READY;
                            // Swap when the head is as good or better; requeue next cycle.
                            if (r_len != '0 && c_prio[0] <= r_run_prio) begin
                                n_in_q[c_id[0]] = 1'b0;
                                n_len           = r_len - LEN_W'(1);
                                cell_cmd        = '{op: CELL_REMOVE, key_prio: '0};
                                key_id          = c_id[0];
                                n_run_slot      = c_id[0];
                                n_run_prio      = c_prio[0];
                                n_req_slot      = r_run_slot;
                                n_req_prio      = r_run_prio;
                                finish          = 1'b0;
                                n_state         = S_REQ;
                            end
                        end
                    end
                endcase
            end

            S_REQ: begin
                finish = 1'b1;
                // A resumed running task is already queued: keep its place.
                if (!r_in_q[r_req_slot]) begin
                    n_in_q[r_req_slot] = 1'b1;
                    n_len              = r_len + LEN_W'(1);
                    cell_cmd           = '{op: CELL_INSERT, key_prio: r_req_prio};
                    key_id             = r_req_slot;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            if (out_free) begin
                load_out = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_state  = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_in_q        <= '0;
            r_len         <= '0;
            r_run_slot    <= '0;
            r_run_present <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < TASKS; i++) begin
                r_slot_st[i] <= ST_UNUSED;
            end
        end else begin
            r_state       <= n_state;
            r_in_q        <= n_in_q;
            r_len         <= n_len;
            r_run_slot    <= n_run_slot;
            r_run_present <= n_run_present;
            r_slot_st     <= n_slot_st;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_op      <= t_op'(i_in.opcode);
            r_prio_in <= i_in.task_priority_in;
            r_id_in   <= i_in.task_id_in;
            r_outc    <= i_in.current_outcome;
        end
        if (prio_we) begin
            r_slot_prio[free_slot] <= r_prio_in;
        end
        r_run_prio   <= n_run_prio;
        r_req_slot   <= n_req_slot;
        r_req_prio   <= n_req_prio;
        r_res_status <= res_status;
        r_res_id     <= res_id;
        if (load_out) begin
            r_out_status    <= res_status;
            r_out_id        <= res_id;
            r_out_run       <= n_run_present ? ID_W'(n_run_slot) : '0;
            r_out_run_valid <= n_run_present;
            r_out_count     <= CNT_W'(n_len);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.task_id_out   = r_out_id;
    assign o_out.running_task  = r_out_run;
    assign o_out.running_valid = r_out_run_valid;
    assign o_out.queue_count   = r_out_count;

endmodule

[rtl/prq_checker.sv]
// Port-level checks for the scheduler, attached to the top level by bind.
// Depends on prq_pkg and the assertion macros header.
`include "priority_ready_queue_scheduler_core_defines.svh"

module prq_checker import prq_pkg::*; #(
    parameter int TASKS = TASKS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [ID_W-1:0]   i_running_task,
    input logic              i_running_valid,
    input logic [CNT_W-1:0]  i_queue_count
);

    // Hold a result beat until it is taken.
    `PRQ_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")

    // Drop nothing into the result channel right after reset.
    `PRQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result beat after reset")

    `PRQ_ASSERT(a_idle_task_zero, i_clk, i_rst_n, i_out_valid && !i_running_valid |-> i_running_task == '0, "running task not zero while idle")

    // An empty status always reports an empty queue.
    `PRQ_ASSERT(a_empty_count, i_clk, i_rst_n, i_out_valid && i_status == STAT_EMPTY |-> i_queue_count == '0, "empty status with queued tasks")

    `PRQ_ASSERT(a_count_range, i_clk, i_rst_n, i_out_valid && TASKS < 16 |-> int'(i_queue_count) <= TASKS, "queue count beyond slot count")

endmodule

bind priority_ready_queue_scheduler_core prq_checker #(
    .TASKS (TASKS)
) u_prq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_running_task  (o_out.running_task),
    .i_running_valid (o_out.running_valid),
    .i_queue_count   (o_out.queue_count)
);
